// ----- src/pfdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfdt_pkg;

   // Item field widths
   localparam int OP_W      = 2;
   localparam int BYTE_W    = 8;
   localparam int LIMIT_W   = 12;
   localparam int STATUS_W  = 2;
   localparam int PEND_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_TAIL       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_ENABLED = 1'd1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_STATUS = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_DROPPED = 2'd1,
      ST_RETRY   = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the request beat
      logic execute;   // update ring state, access the slot memory
      logic finish;    // load the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // response register empty or being taken
   } stat_type;

endpackage

`default_nettype wire

// ----- src/pfdt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfdt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire pfdt_pkg::stat_type stat,
   output pfdt_pkg::cmd_type       cmd
);
   import pfdt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   assign req_stall   = (state_ff != S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.finish  = (state_ff == S_DONE) && stat.out_free;

endmodule

`default_nettype wire

// ----- src/pfdt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfdt_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int SLOT_BYTES  = 2048
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pfdt_pkg::cmd_type                  cmd,
   output pfdt_pkg::stat_type                      stat,
   input  wire logic                               csr_write_en,
   input  wire logic [pfdt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfdt_pkg::CSR_DAT_W-1:0]     csr_write_data,
   input  wire logic [pfdt_pkg::OP_W-1:0]          req_opcode,
   input  wire logic [pfdt_pkg::BYTE_W-1:0]        req_data_byte,
   input  wire logic                               req_end_of_packet,
   input  wire logic [pfdt_pkg::LIMIT_W-1:0]       req_read_limit,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [pfdt_pkg::STATUS_W-1:0]           rsp_status,
   output logic [pfdt_pkg::BYTE_W-1:0]             rsp_out_byte,
   output logic                                    rsp_byte_valid,
   output logic                                    rsp_last_byte,
   output logic                                    rsp_queue_empty,
   output logic [pfdt_pkg::PEND_W-1:0]             rsp_pending_bytes,
   output logic                                    rsp_timer_expired
);
   import pfdt_pkg::*;

   localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int OFF_W     = $clog2(SLOT_BYTES + 1);
   localparam int CMP_W     = (OFF_W > LIMIT_W) ? OFF_W : LIMIT_W;
   localparam int MEM_DEPTH = QUEUE_DEPTH * SLOT_BYTES;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(QUEUE_DEPTH - 1)) r = '0;
      else                              r = i + IDX_W'(1);
      return r;
   endfunction

   // Captured request beat
   op_type              op_ff;
   logic [BYTE_W-1:0]   data_ff;
   logic                eop_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   // Configuration
   logic                drop_tail_ff;
   logic                timeout_en_ff;

   // Ring state
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OFF_W-1:0]    wo_ff, wo_in;
   logic [OFF_W-1:0]    ro_ff, ro_in;
   logic                dropping_ff, dropping_in;
   logic                expired_ff, expired_in;
   logic [PEND_W-1:0]   total_ff, total_in;

   // Slot storage
   logic [BYTE_W-1:0]   slot_mem_ff [MEM_DEPTH];
   logic [OFF_W-1:0]    slot_len_ff [QUEUE_DEPTH];
   logic [BYTE_W-1:0]   rd_data_ff;

   // Result staging
   status_type          st_status_ff, st_status_in;
   logic                st_valid_ff, st_valid_in;
   logic                st_last_ff, st_last_in;
   logic                st_texp_ff, st_texp_in;

   // Response register
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [BYTE_W-1:0]   rsp_out_byte_ff;
   logic                rsp_byte_valid_ff;
   logic                rsp_last_byte_ff;
   logic                rsp_queue_empty_ff;
   logic [PEND_W-1:0]   rsp_pending_ff;
   logic                rsp_texp_ff;

   // Execute stage signals
   logic                mem_we;
   logic                len_we;
   logic [OFF_W-1:0]    wo_next;
   logic [OFF_W-1:0]    ro_next;
   logic [OFF_W-1:0]    head_len;
   logic [CMP_W-1:0]    eff_len;
   logic                ring_full;
   logic [ADDR_W-1:0]   mem_addr;

   assign ring_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_len  = slot_len_ff[head_ff];
   assign eff_len   = (CMP_W'(limit_ff) < CMP_W'(head_len)) ? CMP_W'(limit_ff)
                                                             : CMP_W'(head_len);

   // Slot address: base of the slot plus byte offset
   assign mem_addr = (op_ff == OP_WRITE)
      ? ADDR_W'(tail_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wo_ff)
      : ADDR_W'(head_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(ro_ff);

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_opcode);
         data_ff  <= req_data_byte;
         eop_ff   <= req_end_of_packet;
         limit_ff <= req_read_limit;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_tail_ff  <= 1'b0;
         timeout_en_ff <= 1'b0;
      end else if (csr_write_en) begin
         if (csr_index == CSR_DROP_TAIL)       drop_tail_ff  <= csr_write_data[0];
         if (csr_index == CSR_TIMEOUT_ENABLED) timeout_en_ff <= csr_write_data[0];
      end
   end

   // Ring update for one item
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      wo_in        = wo_ff;
      ro_in        = ro_ff;
      dropping_in  = dropping_ff;
      expired_in   = expired_ff;
      total_in     = total_ff;
      st_status_in = ST_OK;
      st_valid_in  = 1'b0;
      st_last_in   = 1'b0;
      st_texp_in   = 1'b0;
      mem_we       = 1'b0;
      len_we       = 1'b0;
      wo_next      = wo_ff;
      ro_next      = ro_ff;
      case (op_ff)
         OP_WRITE: begin
            if (dropping_ff) begin
               if (eop_ff) dropping_in = 1'b0;
               st_status_in = ST_DROPPED;
            end else if ((wo_ff == '0) && ring_full) begin
               if (drop_tail_ff) begin
                  if (!eop_ff) dropping_in = 1'b1;
                  st_status_in = ST_DROPPED;
               end else begin
                  st_status_in = ST_RETRY;
               end
            end else begin
               // bytes past the slot size are discarded
               if (wo_ff < OFF_W'(SLOT_BYTES)) begin
                  mem_we  = 1'b1;
                  wo_next = wo_ff + OFF_W'(1);
               end
               if (eop_ff) begin
                  len_we   = 1'b1;
                  total_in = total_ff + PEND_W'(wo_next);
                  tail_in  = next_slot(tail_ff);
                  count_in = count_ff + CNT_W'(1);
                  wo_in    = '0;
               end else begin
                  wo_in = wo_next;
               end
            end
         end
         OP_READ: begin
            if (count_ff == '0) begin
               st_status_in = ST_EMPTY;
               if (timeout_en_ff) expired_in = 1'b1;
            end else begin
               if (CMP_W'(ro_ff) < eff_len) begin
                  st_valid_in = 1'b1;
                  ro_next     = ro_ff + OFF_W'(1);
               end
               // pop once the delivered count reaches the limit or the length
               if (CMP_W'(ro_next) >= eff_len) begin
                  st_last_in = 1'b1;
                  total_in   = total_ff - PEND_W'(head_len);
                  head_in    = next_slot(head_ff);
                  count_in   = count_ff - CNT_W'(1);
                  ro_in      = '0;
               end else begin
                  ro_in = ro_next;
               end
            end
         end
         OP_CLEAR: begin
            head_in     = '0;
            tail_in     = '0;
            count_in    = '0;
            wo_in       = '0;
            ro_in       = '0;
            dropping_in = 1'b0;
            total_in    = '0;
         end
         OP_STATUS: begin
            st_texp_in = expired_ff;
            expired_in = 1'b0;
         end
         default: begin
            st_status_in = ST_OK;
         end
      endcase
   end

   // Ring state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         wo_ff       <= '0;
         ro_ff       <= '0;
         dropping_ff <= 1'b0;
         expired_ff  <= 1'b0;
         total_ff    <= '0;
      end else if (cmd.execute) begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         wo_ff       <= wo_in;
         ro_ff       <= ro_in;
         dropping_ff <= dropping_in;
         expired_ff  <= expired_in;
         total_ff    <= total_in;
      end
   end

   // Result staging
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         st_status_ff <= st_status_in;
         st_valid_ff  <= st_valid_in;
         st_last_ff   <= st_last_in;
         st_texp_ff   <= st_texp_in;
      end
   end

   // Slot byte memory, one access per item, registered read
   always_ff @(posedge clock) begin
      if (cmd.execute && mem_we) begin
         slot_mem_ff[mem_addr] <= data_ff;
      end
      if (cmd.execute && (op_ff == OP_READ)) begin
         rd_data_ff <= slot_mem_ff[mem_addr];
      end
   end

   // Committed lengths
   always_ff @(posedge clock) begin
      if (cmd.execute && len_we) begin
         slot_len_ff[tail_ff] <= wo_next;
      end
   end

   // Response register
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff      <= st_status_ff;
         rsp_out_byte_ff    <= st_valid_ff ? rd_data_ff : '0;
         rsp_byte_valid_ff  <= st_valid_ff;
         rsp_last_byte_ff   <= st_last_ff;
         rsp_queue_empty_ff <= (count_ff == '0);
         rsp_pending_ff     <= total_ff;
         rsp_texp_ff        <= st_texp_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_byte      = rsp_out_byte_ff;
   assign rsp_byte_valid    = rsp_byte_valid_ff;
   assign rsp_last_byte     = rsp_last_byte_ff;
   assign rsp_queue_empty   = rsp_queue_empty_ff;
   assign rsp_pending_bytes = rsp_pending_ff;
   assign rsp_timer_expired = rsp_texp_ff;

`ifndef NO_ASSERTIONS
   // Packet count never exceeds the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("packet count above ring depth");

   // Empty or full ring has head and tail on the same slot
   a_ring_ptrs: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) || ring_full) |-> (head_ff == tail_ff))
      else $error("ring pointers disagree with packet count");

   // Dropping only ever starts at a packet boundary
   a_drop_open: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> (wo_ff == '0))
      else $error("dropping with a partly written packet");

   // A delivered byte always comes with ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_byte_valid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("payload byte with non-ok status");
`endif

endmodule

`default_nettype wire

// ----- src/packet_fifo_drop_tail.sv -----
// Channel   Ports                      Beat
// request   req_valid / req_stall      opcode, data byte, end flag, read limit
// response  rsp_valid / rsp_stall      status, byte, flags, pending total
// csr       csr_write_en               drop_tail (0), timeout_enabled (1)
//
// Each item passes through capture, ring update with one slot memory access and
// response load. The slot memory read latency sets the middle step.
// A new request is taken while the previous response still waits on rsp_stall;
// the item then holds in its last step until the response register frees.
// Synchronous reset empties the ring at once; slot memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module packet_fifo_drop_tail #(
   parameter int QUEUE_DEPTH = 16,
   parameter int SLOT_BYTES  = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [pfdt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pfdt_pkg::CSR_DAT_W-1:0] csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [pfdt_pkg::OP_W-1:0]      req_opcode,
   input  wire logic [pfdt_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                           req_end_of_packet,
   input  wire logic [pfdt_pkg::LIMIT_W-1:0]   req_read_limit,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [pfdt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pfdt_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                rsp_byte_valid,
   output logic                                rsp_last_byte,
   output logic                                rsp_queue_empty,
   output logic [pfdt_pkg::PEND_W-1:0]         rsp_pending_bytes,
   output logic                                rsp_timer_expired
);
   import pfdt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   pfdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Ring, slot storage and response register
   pfdt_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SLOT_BYTES  (SLOT_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_opcode),
      .req_data_byte     (req_data_byte),
      .req_end_of_packet (req_end_of_packet),
      .req_read_limit    (req_read_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_pending_bytes (rsp_pending_bytes),
      .rsp_timer_expired (rsp_timer_expired)
   );

endmodule

`default_nettype wire

// ----- dv/packet_fifo_drop_tail_tb.sv -----
`timescale 1ns / 1ps

module packet_fifo_drop_tail_tb;
   import pfdt_pkg::*;

   localparam int QD = 16;
   localparam int SB = 2048;

   typedef struct packed {
      op_type               op;
      logic [BYTE_W-1:0]    data;
      logic                 eop;
      logic [LIMIT_W-1:0]   limit;
   } ring_req_type;

   typedef struct packed {
      status_type           status;
      logic [BYTE_W-1:0]    out_byte;
      logic                 byte_valid;
      logic                 last_byte;
      logic                 queue_empty;
      logic [PEND_W-1:0]    pending;
      logic                 timer_expired;
   } ring_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_opcode = '0;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 req_end_of_packet = 1'b0;
   logic [LIMIT_W-1:0]   req_read_limit = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_last_byte;
   logic                 rsp_queue_empty;
   logic [PEND_W-1:0]    rsp_pending_bytes;
   logic                 rsp_timer_expired;

   packet_fifo_drop_tail #(
      .QUEUE_DEPTH(QD),
      .SLOT_BYTES (SB)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_end_of_packet(req_end_of_packet),
      .req_read_limit   (req_read_limit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_queue_empty  (rsp_queue_empty),
      .rsp_pending_bytes(rsp_pending_bytes),
      .rsp_timer_expired(rsp_timer_expired)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Ring model state
   logic [BYTE_W-1:0] slot_mem [0:QD*SB-1];
   int  slot_len [0:QD-1];
   int  head = 0, tail = 0, count = 0, wr_off = 0, rd_off = 0, total = 0;
   bit  dropping = 0, expired = 0;
   bit  cfg_drop = 0, cfg_timeout = 0;

   ring_req_type    beats_to_send [$];
   ring_result_type results_due [$];
   int  mismatches = 0;
   int  rsp_count = 0;
   bit  req_taken = 0;
   bit  calm = 0;

   // Advance the ring model by one request beat and return its response
   function automatic ring_result_type ring_predict(ring_req_type rq);
      ring_result_type r;
      int len;
      int eff;
      r = '0;
      r.status = ST_OK;
      case (rq.op)
         OP_WRITE: begin
            if (dropping) begin
               if (rq.eop) dropping = 0;
               r.status = ST_DROPPED;
            end else if (wr_off == 0 && count >= QD) begin
               // full ring at packet start
               if (cfg_drop) begin
                  if (!rq.eop) dropping = 1;
                  r.status = ST_DROPPED;
               end else begin
                  r.status = ST_RETRY;
               end
            end else begin
               // bytes past the slot size are discarded
               if (wr_off < SB) begin
                  slot_mem[tail*SB + wr_off] = rq.data;
                  wr_off++;
               end
               if (rq.eop) begin
                  slot_len[tail] = wr_off;
                  total += wr_off;
                  tail = (tail + 1) % QD;
                  count++;
                  wr_off = 0;
               end
            end
         end
         OP_READ: begin
            if (count == 0) begin
               r.status = ST_EMPTY;
               if (cfg_timeout) expired = 1;
            end else begin
               len = slot_len[head];
               eff = (int'(rq.limit) < len) ? int'(rq.limit) : len;
               if (rd_off < eff) begin
                  r.out_byte = slot_mem[head*SB + rd_off];
                  r.byte_valid = 1'b1;
                  rd_off++;
               end
               // pop once the limit or the packet end is reached
               if (rd_off >= eff) begin
                  r.last_byte = 1'b1;
                  total -= len;
                  head = (head + 1) % QD;
                  count--;
                  rd_off = 0;
               end
            end
         end
         OP_CLEAR: begin
            head = 0;
            tail = 0;
            count = 0;
            wr_off = 0;
            rd_off = 0;
            dropping = 0;
            total = 0;
         end
         default: begin
            r.timer_expired = expired;
            expired = 0;
         end
      endcase
      r.queue_empty = (count == 0);
      r.pending = PEND_W'(total);
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sample both channels and the csr port at the rising edge
   always @(posedge clock) begin
      ring_req_type    rq;
      ring_result_type want;
      if (!reset) begin
         if (csr_write_en) begin
            if (csr_index == CSR_DROP_TAIL) cfg_drop = csr_write_data[0];
            else if (csr_index == CSR_TIMEOUT_ENABLED) cfg_timeout = csr_write_data[0];
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (results_due.size() == 0) begin
               $display("%0t: response beat with none expected, status %0d", $time,
                        rsp_status);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_valid", want.byte_valid, rsp_byte_valid);
               check_field("last_byte", want.last_byte, rsp_last_byte);
               check_field("queue_empty", want.queue_empty, rsp_queue_empty);
               check_field("pending_bytes", want.pending, rsp_pending_bytes);
               check_field("timer_expired", want.timer_expired, rsp_timer_expired);
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1;
            rq.op    = op_type'(req_opcode);
            rq.data  = req_data_byte;
            rq.eop   = req_end_of_packet;
            rq.limit = req_read_limit;
            results_due.push_back(ring_predict(rq));
         end
      end
   end

   // Request driver: one beat at a time from the pending queue, random gaps
   int gap_left = 0;
   int tx_quiet = 0;

   always @(negedge clock) begin
      ring_req_type it;
      bit nv;
      nv = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 0;
         nv = 0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (beats_to_send.size() != 0) begin
            if (!calm && tx_quiet == 0 && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 12);
            end else begin
               it = beats_to_send.pop_front();
               nv = 1;
               req_opcode        <= it.op;
               req_data_byte     <= it.data;
               req_end_of_packet <= it.eop;
               req_read_limit    <= it.limit;
            end
            if (tx_quiet > 0) tx_quiet--;
            else if ($urandom_range(0, 59) == 0) tx_quiet = $urandom_range(20, 80);
         end
      end
      req_valid <= nv;
   end

   // Response stall: random bursts, plus one long hold-off to back up the block
   int stall_left = 0;
   int hold_left = 0;
   int rx_quiet = 0;
   bit long_done = 0;

   always @(negedge clock) begin
      bit st;
      st = 0;
      if (!long_done && rsp_count >= 400) begin
         long_done = 1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         st = 1;
         hold_left--;
      end else if (stall_left > 0 && !calm) begin
         st = 1;
         stall_left--;
      end else if (!calm && rx_quiet == 0 && $urandom_range(0, 3) == 0) begin
         st = 1;
         stall_left = $urandom_range(0, 12);
      end
      if (rx_quiet > 0) rx_quiet--;
      else if ($urandom_range(0, 59) == 0) rx_quiet = $urandom_range(20, 80);
      rsp_stall <= st;
   end

   function automatic void queue_beat(op_type op, logic [BYTE_W-1:0] d, logic eop,
                                      logic [LIMIT_W-1:0] lim);
      ring_req_type b;
      b.op    = op;
      b.data  = d;
      b.eop   = eop;
      b.limit = lim;
      beats_to_send.push_back(b);
   endfunction

   // A packet of random bytes, end flag on the last beat
   function automatic void queue_packet(int len);
      for (int i = 0; i < len; i++)
         queue_beat(OP_WRITE, BYTE_W'($urandom), (i == len - 1), LIMIT_W'($urandom));
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return LIMIT_W'(SB);
      if (r < 6) return {LIMIT_W{1'b1}};
      if (r == 6) return '0;
      if (r < 9) return LIMIT_W'($urandom_range(1, 6));
      return LIMIT_W'($urandom);
   endfunction

   // Mixed traffic, alternating between filling and draining stretches
   function automatic void queue_traffic(int n);
      int stop;
      int r;
      int runs;
      bit fill;
      logic [LIMIT_W-1:0] lim;
      stop = beats_to_send.size() + n;
      fill = 1;
      while (beats_to_send.size() < stop) begin
         if ($urandom_range(0, 29) == 0) fill = !fill;
         r = $urandom_range(0, 99);
         if (r < (fill ? 70 : 30)) begin
            queue_packet(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                    : $urandom_range(1, 6));
         end else if (r < 92) begin
            runs = $urandom_range(1, 8);
            lim = pick_limit();
            for (int i = 0; i < runs; i++) begin
               if ($urandom_range(0, 7) == 0) lim = pick_limit();
               queue_beat(OP_READ, BYTE_W'($urandom), 1'($urandom), lim);
            end
         end else if (r < 95) begin
            queue_beat(OP_STATUS, BYTE_W'($urandom), 1'($urandom), LIMIT_W'($urandom));
         end else if (r < 96) begin
            queue_beat(OP_CLEAR, BYTE_W'($urandom), 1'($urandom), LIMIT_W'($urandom));
         end else begin
            queue_beat(op_type'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom),
                       LIMIT_W'($urandom));
         end
      end
   endfunction

   // Checked at the rising edge, where the driver's outputs are settled
   task automatic drain_wait();
      @(posedge clock);
      while (beats_to_send.size() != 0 || results_due.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      bit d;
      bit t;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         drain_wait();
         repeat (4) @(negedge clock);
         case (ph)
            0: begin d = 1; t = 1; end
            1: begin d = 0; t = 0; end
            2: begin d = 1; t = 0; end
            3: begin d = 0; t = 1; end
            default: begin d = 1; t = 1; end
         endcase
         csr_write_en   <= 1'b1;
         csr_index      <= CSR_DROP_TAIL;
         csr_write_data <= d;
         @(negedge clock);
         csr_index      <= CSR_TIMEOUT_ENABLED;
         csr_write_data <= t;
         @(negedge clock);
         csr_write_en   <= 1'b0;
         @(posedge clock);
         case (ph)
            0: begin
               // expiry flag: clear on status, set by an empty read
               queue_beat(OP_STATUS, 8'h00, 1'b0, 12'd0);
               queue_beat(OP_READ, 8'hFF, 1'b1, 12'd2048);
               queue_beat(OP_STATUS, 8'h00, 1'b0, 12'd0);
               queue_beat(OP_STATUS, 8'h00, 1'b0, 12'd0);
               // one-byte packet, then a two-byte one
               queue_beat(OP_WRITE, 8'hFF, 1'b1, 12'hFFF);
               queue_beat(OP_WRITE, 8'h00, 1'b0, 12'd0);
               queue_beat(OP_WRITE, 8'hA5, 1'b1, 12'd0);
               // zero limit pops with no byte
               queue_beat(OP_READ, 8'h00, 1'b0, 12'd0);
               // limit lowered mid-packet
               queue_beat(OP_READ, 8'h00, 1'b0, 12'hFFF);
               queue_beat(OP_READ, 8'h00, 1'b0, 12'd1);
               // clear drops the open packet
               queue_beat(OP_WRITE, 8'h11, 1'b0, 12'd0);
               queue_beat(OP_WRITE, 8'h22, 1'b0, 12'd0);
               queue_beat(OP_CLEAR, 8'h00, 1'b0, 12'd0);
               queue_beat(OP_WRITE, 8'h33, 1'b1, 12'd0);
               queue_beat(OP_READ, 8'h00, 1'b0, 12'd2048);
               queue_beat(OP_READ, 8'h00, 1'b0, 12'd2048);
               // flag survives a clear
               queue_beat(OP_CLEAR, 8'hFF, 1'b1, 12'hFFF);
               queue_beat(OP_STATUS, 8'hFF, 1'b1, 12'hFFF);
               queue_traffic(100);
            end
            1: begin
               // oversized packet, then truncated at its third byte
               queue_beat(OP_CLEAR, 8'h00, 1'b0, 12'd0);
               queue_packet(SB + 2);
               queue_beat(OP_STATUS, 8'h00, 1'b0, 12'd0);
               for (int i = 0; i < 2; i++) queue_beat(OP_READ, 8'h00, 1'b0, 12'hFFF);
               queue_beat(OP_READ, 8'h00, 1'b0, 12'd2);
               queue_traffic(20);
            end
            4: begin
               calm = 1;
               queue_traffic(60);
            end
            default: queue_traffic(100);
         endcase
      end
      drain_wait();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("packet_fifo_drop_tail: match");
      else
         $display("packet_fifo_drop_tail: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("packet_fifo_drop_tail: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
src/pfdt_pkg.sv
src/pfdt_ctrl.sv
src/pfdt_datapath.sv
src/packet_fifo_drop_tail.sv
dv/packet_fifo_drop_tail_tb.sv
